// ===== design/scbt_pkg.sv =====
// ---------------------------------------------------------------------------
// scbt_pkg
// Shared widths, register indexes and the segment record type for the
// segment box clearance test unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scbt_pkg;

  localparam int CB        = 30;        // coordinate width
  localparam int MB        = 25;        // margin width
  localparam int SB        = 24;        // spacing width
  localparam int DW        = CB + 1;    // coordinate difference
  localparam int LW        = CB + 2;    // grown bounds and lane values
  localparam int XW        = CB + 3;    // slab numerators and multiplier operands
  localparam int PW        = 2 * XW;    // multiplier product
  localparam int SQW       = 64;        // squared length and root work
  localparam int QW        = 32;        // divider dividend
  localparam int NUM_LANES = 4;         // x, y, z, altitude
  localparam int NUM_REGS  = 8;
  localparam int CIW       = 3;

  localparam logic [1:0] LANE_ALT = 2'd3;
  localparam logic [1:0] LANE_Z   = 2'd2;

  localparam logic [CIW-1:0] REG_BOX_MIN_X   = 3'd0;
  localparam logic [CIW-1:0] REG_BOX_MIN_Y   = 3'd1;
  localparam logic [CIW-1:0] REG_BOX_MIN_Z   = 3'd2;
  localparam logic [CIW-1:0] REG_BOX_MAX_X   = 3'd3;
  localparam logic [CIW-1:0] REG_BOX_MAX_Y   = 3'd4;
  localparam logic [CIW-1:0] REG_BOX_MAX_Z   = 3'd5;
  localparam logic [CIW-1:0] REG_ALT_FLOOR   = 3'd6;
  localparam logic [CIW-1:0] REG_ALT_CEILING = 3'd7;

  localparam logic signed [CB-1:0] ALT_CEILING_RST = -30'sd100;

  typedef struct packed {
    logic [NUM_LANES-1:0][CB-1:0] s;   // start point per lane
    logic [NUM_LANES-1:0][DW-1:0] d;   // end minus start per lane
    logic [NUM_LANES-1:0][LW-1:0] lo;  // grown lower bound per lane
    logic [NUM_LANES-1:0][LW-1:0] hi;  // grown upper bound per lane
    logic                         band_en;
    logic [SB-1:0]                step;
  } seg_rec_t;

  localparam int REC_W = $bits(seg_rec_t);

endpackage

// ===== design/scbt_div.sv =====
// ---------------------------------------------------------------------------
// scbt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbt_div #(
  parameter int NW = 32,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [VW:0]   trial;
  logic          ge;
  logic [VW-1:0] rem_nxt;
  logic [NW-1:0] quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= CW'(NW);
        run_r <= 1'b1;
      end else if (run_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== design/scbt_queue.sv =====
// ---------------------------------------------------------------------------
// scbt_queue
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbt_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= din;
        wp_r        <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign dout  = mem_r[rp_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

endmodule

// ===== design/scbt_front.sv =====
// ---------------------------------------------------------------------------
// scbt_front
// Holds the configuration registers, takes items and turns each into a
// record of start points, deltas and clearance-grown bounds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbt_front import scbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CB-1:0] in_start_x,
  input  logic signed [CB-1:0] in_start_y,
  input  logic signed [CB-1:0] in_start_z,
  input  logic signed [CB-1:0] in_end_x,
  input  logic signed [CB-1:0] in_end_y,
  input  logic signed [CB-1:0] in_end_z,
  input  logic signed [CB-1:0] in_start_altitude,
  input  logic signed [CB-1:0] in_end_altitude,
  input  logic signed [MB-1:0] in_horizontal_margin,
  input  logic signed [MB-1:0] in_vertical_margin,
  input  logic        [SB-1:0] in_sample_spacing,
  input  logic                 cfg_we,
  input  logic       [CIW-1:0] cfg_index,
  input  logic        [CB-1:0] cfg_wdata,
  input  logic                 q_full,
  output logic                 push,
  output seg_rec_t             rec
);

  logic signed [CB-1:0] cfg_r [NUM_REGS];
  seg_rec_t             rec_r;
  seg_rec_t             rec_nxt;
  logic                 valid_r;
  logic                 accept;
  logic signed [MB-1:0] hm;
  logic signed [MB-1:0] vm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= '0;
      cfg_r[REG_ALT_CEILING] <= ALT_CEILING_RST;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    hm = in_horizontal_margin[MB-1] ? '0 : in_horizontal_margin;
    vm = in_vertical_margin[MB-1] ? '0 : in_vertical_margin;

    rec_nxt.s[0] = in_start_x;
    rec_nxt.s[1] = in_start_y;
    rec_nxt.s[2] = in_start_z;
    rec_nxt.s[3] = in_start_altitude;
    rec_nxt.d[0] = DW'(in_end_x) - DW'(in_start_x);
    rec_nxt.d[1] = DW'(in_end_y) - DW'(in_start_y);
    rec_nxt.d[2] = DW'(in_end_z) - DW'(in_start_z);
    rec_nxt.d[3] = DW'(in_end_altitude) - DW'(in_start_altitude);

    rec_nxt.lo[0] = LW'(cfg_r[REG_BOX_MIN_X]) - LW'(hm);
    rec_nxt.lo[1] = LW'(cfg_r[REG_BOX_MIN_Y]) - LW'(hm);
    rec_nxt.lo[2] = LW'(cfg_r[REG_BOX_MIN_Z]) - LW'(vm);
    rec_nxt.lo[3] = LW'(cfg_r[REG_ALT_FLOOR]) - LW'(vm);
    rec_nxt.hi[0] = LW'(cfg_r[REG_BOX_MAX_X]) + LW'(hm);
    rec_nxt.hi[1] = LW'(cfg_r[REG_BOX_MAX_Y]) + LW'(hm);
    rec_nxt.hi[2] = LW'(cfg_r[REG_BOX_MAX_Z]) + LW'(vm);
    rec_nxt.hi[3] = LW'(cfg_r[REG_ALT_CEILING]) + LW'(vm);

    rec_nxt.band_en = cfg_r[REG_ALT_CEILING] >= cfg_r[REG_ALT_FLOOR];
    rec_nxt.step    = (in_sample_spacing == '0) ? SB'(1) : in_sample_spacing;
  end

  assign push   = valid_r && !q_full;
  assign busy   = valid_r && q_full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (accept) valid_r <= 1'b1;
      else if (push) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

// ===== design/scbt_back.sv =====
// ---------------------------------------------------------------------------
// scbt_back
// Sequencer: exact slab test on a shared multiplier; with the altitude band
// enabled, length by bitwise square root, step count and lerp increments on
// a shared divider, then one sample point per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbt_back import scbt_pkg::*; #(
  parameter int MAX_STEPS = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  seg_rec_t q_data,
  output logic     pop,
  output logic     out_valid,
  output logic     out_touches_zone
);

  localparam int NB = $clog2(MAX_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_MUL, S_SQ, S_SQRT, S_DIVN, S_DIVL, S_SAMPLE
  } state_t;

  state_t              state_r;
  seg_rec_t            rec_r;
  logic [1:0]          axis_r;
  logic [2:0]          ms_r;
  logic signed [XW-1:0] a_r, b_r, den_r;
  logic signed [XW-1:0] ln_r, ld_r, hn_r, hd_r;
  logic signed [PW-1:0] prod_r, prev_r;
  logic [SQW-1:0]      acc_r, v_r, r_r;
  logic [4:0]          it_r;
  logic                wait_r;
  logic [NB-1:0]       n_r, k_r;
  logic signed [LW-1:0] qs_r [NUM_LANES];
  logic [NB-1:0]       rs_r [NUM_LANES];
  logic signed [LW-1:0] dq_r [NUM_LANES];
  logic [NB-1:0]       dr_r [NUM_LANES];
  logic                out_valid_r, out_touch_r;

  // setup of one slab
  logic signed [XW-1:0] s_ax, d_ax, lo_ax, hi_ax, a0, b0, an, bn, den;
  logic                 dneg, in_slab, last_axis;
  // multiplier
  logic signed [XW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_nxt;
  // root
  logic [SQW-1:0]       sq_bit, rb;
  logic                 sq_ge;
  // divider
  logic                 div_start, div_done;
  logic [QW-1:0]        div_num, div_q;
  logic [SB-1:0]        div_dvs, div_r;
  logic [NB-1:0]        n_val;
  logic signed [LW-1:0] dq_val;
  logic [NB-1:0]        dr_val, ra;
  // sampling
  logic [NUM_LANES-1:0] lane_in;
  logic signed [LW-1:0] qs_nxt [NUM_LANES];
  logic [NB-1:0]        rs_nxt [NUM_LANES];

  always_comb begin
    s_ax   = XW'($signed(rec_r.s[axis_r]));
    d_ax   = XW'($signed(rec_r.d[axis_r]));
    lo_ax  = XW'($signed(rec_r.lo[axis_r]));
    hi_ax  = XW'($signed(rec_r.hi[axis_r]));
    dneg   = d_ax < 0;
    a0     = lo_ax - s_ax;
    b0     = hi_ax - s_ax;
    an     = dneg ? -a0 : a0;
    bn     = dneg ? -b0 : b0;
    den    = dneg ? -d_ax : d_ax;
    in_slab   = (s_ax >= lo_ax) && (s_ax <= hi_ax);
    last_axis = axis_r == LANE_Z;
  end

  always_comb begin
    mul_a = a_r;
    mul_b = ld_r;
    if (state_r == S_SQ) begin
      mul_a = XW'($signed(rec_r.d[ms_r[1:0]]));
      mul_b = mul_a;
    end else begin
      case (ms_r)
        3'd0: begin mul_a = a_r;  mul_b = ld_r;  end
        3'd1: begin mul_a = ln_r; mul_b = den_r; end
        3'd2: begin mul_a = b_r;  mul_b = hd_r;  end
        3'd3: begin mul_a = hn_r; mul_b = den_r; end
        3'd5: begin mul_a = ln_r; mul_b = hd_r;  end
        3'd6: begin mul_a = hn_r; mul_b = ld_r;  end
        default: begin mul_a = a_r; mul_b = ld_r; end
      endcase
    end
    prod_nxt = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    sq_bit = SQW'(1) << {it_r, 1'b0};
    rb     = r_r + sq_bit;
    sq_ge  = v_r >= rb;
  end

  always_comb begin
    div_start = ((state_r == S_DIVN) || (state_r == S_DIVL)) && !wait_r;
    if (state_r == S_DIVN) begin
      div_num = QW'(r_r) + QW'(rec_r.step) - QW'(1);
      div_dvs = rec_r.step;
    end else begin
      div_num = QW'(dneg ? -d_ax : d_ax);
      div_dvs = SB'(n_r);
    end
    if (div_q == '0) n_val = NB'(1);
    else if (div_q > QW'(MAX_STEPS)) n_val = NB'(MAX_STEPS);
    else n_val = div_q[NB-1:0];
    // floor division for a negative delta
    ra = div_r[NB-1:0];
    if (dneg && ra != '0) begin
      dq_val = -LW'(div_q) - LW'(1);
      dr_val = n_r - ra;
    end else if (dneg) begin
      dq_val = -LW'(div_q);
      dr_val = '0;
    end else begin
      dq_val = LW'(div_q);
      dr_val = ra;
    end
  end

  scbt_div #(.NW(QW), .VW(SB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic signed [LW-1:0] p;
    logic [NB:0]          rsum;
    logic                 c;
    always_comb begin
      // truncate toward zero from the floor form
      p          = qs_r[i] + LW'((qs_r[i] < 0) && (rs_r[i] != '0));
      lane_in[i] = (p >= $signed(rec_r.lo[i])) && (p <= $signed(rec_r.hi[i]));
      rsum       = {1'b0, rs_r[i]} + {1'b0, dr_r[i]};
      c          = rsum >= {1'b0, n_r};
      rs_nxt[i]  = c ? NB'(rsum - {1'b0, n_r}) : rsum[NB-1:0];
      qs_nxt[i]  = qs_r[i] + dq_r[i] + LW'(c);
    end
  end

  assign pop = (state_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_touch_r <= 1'b0;
      wait_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      prod_r      <= prod_nxt;
      prev_r      <= prod_r;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            rec_r   <= q_data;
            axis_r  <= '0;
            ln_r    <= '0;
            ld_r    <= XW'(1);
            hn_r    <= XW'(1);
            hd_r    <= XW'(1);
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (d_ax == '0) begin
            if (!in_slab) begin
              out_valid_r <= 1'b1;
              out_touch_r <= 1'b0;
              state_r     <= S_IDLE;
            end else if (!last_axis) begin
              axis_r <= axis_r + 1'b1;
            end else if (rec_r.band_en) begin
              ms_r    <= '0;
              acc_r   <= '0;
              state_r <= S_SQ;
            end else begin
              out_valid_r <= 1'b1;
              out_touch_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else begin
            a_r     <= (an > bn) ? bn : an;
            b_r     <= (an > bn) ? an : bn;
            den_r   <= den;
            ms_r    <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          ms_r <= ms_r + 1'b1;
          case (ms_r)
            3'd2: if (prev_r > prod_r) begin ln_r <= a_r; ld_r <= den_r; end
            3'd4: if (prev_r < prod_r) begin hn_r <= b_r; hd_r <= den_r; end
            3'd7: begin
              if (prev_r > prod_r) begin
                out_valid_r <= 1'b1;
                out_touch_r <= 1'b0;
                state_r     <= S_IDLE;
              end else if (!last_axis) begin
                axis_r  <= axis_r + 1'b1;
                state_r <= S_SETUP;
              end else if (rec_r.band_en) begin
                ms_r    <= '0;
                acc_r   <= '0;
                state_r <= S_SQ;
              end else begin
                out_valid_r <= 1'b1;
                out_touch_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end
            default: ;
          endcase
        end
        S_SQ: begin
          ms_r <= ms_r + 1'b1;
          if (ms_r != '0) acc_r <= acc_r + prod_r[SQW-1:0];
          if (ms_r == 3'd3) begin
            v_r     <= acc_r + prod_r[SQW-1:0];
            r_r     <= '0;
            it_r    <= 5'd31;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            v_r <= v_r - rb;
            r_r <= (r_r >> 1) + sq_bit;
          end else begin
            r_r <= r_r >> 1;
          end
          it_r <= it_r - 1'b1;
          if (it_r == '0) begin
            wait_r  <= 1'b0;
            state_r <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_start) wait_r <= 1'b1;
          if (div_done) begin
            n_r     <= n_val;
            axis_r  <= '0;
            wait_r  <= 1'b0;
            state_r <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_start) wait_r <= 1'b1;
          if (div_done) begin
            dq_r[axis_r] <= dq_val;
            dr_r[axis_r] <= dr_val;
            qs_r[axis_r] <= LW'($signed(rec_r.s[axis_r]));
            rs_r[axis_r] <= '0;
            wait_r       <= 1'b0;
            if (axis_r == LANE_ALT) begin
              k_r     <= '0;
              state_r <= S_SAMPLE;
            end else begin
              axis_r <= axis_r + 1'b1;
            end
          end
        end
        S_SAMPLE: begin
          if (&lane_in) begin
            out_valid_r <= 1'b1;
            out_touch_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (k_r == n_r) begin
            out_valid_r <= 1'b1;
            out_touch_r <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            // advance every lane by one step
            for (int i = 0; i < NUM_LANES; i++) begin
              qs_r[i] <= qs_nxt[i];
              rs_r[i] <= rs_nxt[i];
            end
            k_r <= k_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_touches_zone = out_touch_r;

endmodule

// ===== design/segment_box_clearance_test_unit.sv =====
// An item that misses the grown box or needs no band check ends after the slab
// test; with the band check it goes on to the root, divisions and up to MAX_STEPS sample steps.
// Throughput: one item at a time in the back sequencer, set by the serial
// divider (five divisions per item) and one sample point per cycle.
// Reset (rst_n low, synchronous) resets the queue, the configuration registers
// and the control state; the receiver cannot stall, so each result is a one-cycle strobe.
// ---------------------------------------------------------------------------
// segment_box_clearance_test_unit
// Tests 3D segments against a clearance-grown zone box and altitude band.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_box_clearance_test_unit import scbt_pkg::*; #(
  parameter int MAX_STEPS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CB-1:0] in_start_x,
  input  logic signed [CB-1:0] in_start_y,
  input  logic signed [CB-1:0] in_start_z,
  input  logic signed [CB-1:0] in_end_x,
  input  logic signed [CB-1:0] in_end_y,
  input  logic signed [CB-1:0] in_end_z,
  input  logic signed [CB-1:0] in_start_altitude,
  input  logic signed [CB-1:0] in_end_altitude,
  input  logic signed [MB-1:0] in_horizontal_margin,
  input  logic signed [MB-1:0] in_vertical_margin,
  input  logic        [SB-1:0] in_sample_spacing,
  output logic                 out_valid,
  output logic                 out_touches_zone,
  input  logic                 cfg_we,
  input  logic       [CIW-1:0] cfg_index,
  input  logic        [CB-1:0] cfg_wdata
);

  seg_rec_t front_rec;
  seg_rec_t q_data;
  logic     push, pop, q_full, q_empty;

  scbt_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_start_x           (in_start_x),
    .in_start_y           (in_start_y),
    .in_start_z           (in_start_z),
    .in_end_x             (in_end_x),
    .in_end_y             (in_end_y),
    .in_end_z             (in_end_z),
    .in_start_altitude    (in_start_altitude),
    .in_end_altitude      (in_end_altitude),
    .in_horizontal_margin (in_horizontal_margin),
    .in_vertical_margin   (in_vertical_margin),
    .in_sample_spacing    (in_sample_spacing),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .q_full               (q_full),
    .push                 (push),
    .rec                  (front_rec)
  );

  scbt_queue #(.W(REC_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_rec),
    .pop   (pop),
    .dout  (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  scbt_back #(.MAX_STEPS(MAX_STEPS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_touches_zone (out_touches_zone)
  );

endmodule
